>>> hw/rtl/sapstep_pkg.sv
// ----------------------------------------------------------------------------
// sapstep_pkg: shared types and constants for the seek/arrive position step
// Sequencer states, request struct for the shared root/divide unit, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package sapstep_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DECIDE,
        ST_MV_MUL1,
        ST_MV_DIV_GO,
        ST_MV_DIV_WAIT,
        ST_MV_MUL2,
        ST_MV_UPD,
        ST_DONE
    } t_state;

    // request to the shared root/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_iter_req;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_X  = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y  = 3'd1;
    localparam logic [2:0] CFG_TARGET_Z  = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED = 3'd3;
    localparam logic [2:0] CFG_ENABLED   = 3'd4;
    localparam logic [2:0] CFG_REACH_TOL = 3'd5;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    localparam logic [23:0] MAX_SPEED_RST = 24'd655360;
    localparam logic [23:0] REACH_TOL_RST = 24'd655;
    localparam logic [33:0] REST_LIMIT    = 34'd655;

    localparam logic [5:0] SQRT_STEPS = 6'd34;
    localparam logic [5:0] DIV_STEPS  = 6'd24;

endpackage

>>> hw/rtl/sapstep_mul.sv
// ----------------------------------------------------------------------------
// sapstep_mul: shared 32x32 unsigned multiplier
// One product per cycle, result registered.
// ----------------------------------------------------------------------------
module sapstep_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/sapstep_iter.sv
// ----------------------------------------------------------------------------
// sapstep_iter: shared square root / divide unit
// One compare-subtract per cycle. Root mode: 2 radicand bits per step,
// 34 steps. Divide mode: 1 numerator bit per step, 24 quotient bits.
// ----------------------------------------------------------------------------
module sapstep_iter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sapstep_pkg::t_iter_req i_req,
    input  logic [65:0]           i_rad,
    input  logic [55:0]           i_num,
    input  logic [33:0]           i_den,
    output logic                  o_done,
    output logic [33:0]           o_res
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_is_div;
    logic [67:0] r_src;
    logic [37:0] r_rem;
    logic [33:0] r_root;
    logic [33:0] r_den;

    logic [37:0] w_shift;
    logic [37:0] w_trial;
    logic [37:0] w_diff;
    logic        w_ge;

    always_comb begin
        if (r_is_div) begin
            w_shift = {r_rem[36:0], r_src[67]};
            w_trial = {4'b0, r_den};
        end else begin
            w_shift = {r_rem[35:0], r_src[67:66]};
            w_trial = {2'b0, r_root, 2'b01};
        end
        w_diff = w_shift - w_trial;
        w_ge   = (w_shift >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.is_div ? sapstep_pkg::DIV_STEPS : sapstep_pkg::SQRT_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_root   <= '0;
            r_den    <= i_den;
            if (i_req.is_div) begin
                // quotient fits 24 bits, so the top 32 numerator bits are below den
                r_src <= {i_num[23:0], 44'b0};
                r_rem <= {6'b0, i_num[55:24]};
            end else begin
                r_src <= {2'b0, i_rad};
                r_rem <= '0;
            end
        end else if (r_busy) begin
            r_src  <= r_is_div ? {r_src[66:0], 1'b0} : {r_src[65:0], 2'b0};
            r_rem  <= w_ge ? w_diff : w_shift;
            r_root <= {r_root[32:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_root;

endmodule

>>> hw/rtl/seek_arrive_position_step_core.sv
// ----------------------------------------------------------------------------
// seek_arrive_position_step_core: seek-and-arrive steering for one 3D agent
// A tick steers the agent toward the target and advances its position; a
// place request loads the position. Every request returns one result.
// ----------------------------------------------------------------------------
// One request at a time. A moving tick makes two distance passes (square and
// accumulate each axis, then a start and a 34-step square root), and between
// them, per axis, a multiply, a 24-step divide and a second multiply. A place
// request, a frozen tick or a resting tick makes one distance pass. While the
// output register is not free, the block waits at the end of the request until
// the result is taken. The run time is set mostly by the shared root/divide
// unit, which resolves one bit per cycle. A finished result sits in the output
// register while the next request is taken. No clearing pass after reset.
module seek_arrive_position_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_dt,
    input  logic [31:0] i_place_x,
    input  logic [31:0] i_place_y,
    input  logic [31:0] i_place_z,
    // result
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic [31:0] o_pos_z,
    output logic [31:0] o_vel_x,
    output logic [31:0] o_vel_y,
    output logic [31:0] o_vel_z,
    output logic        o_at_rest,
    output logic        o_reached
);

    sapstep_pkg::t_state r_state, n_state;

    logic [31:0] r_tgt [3];
    logic [23:0] r_ms;
    logic        r_en;
    logic [23:0] r_tol;
    logic [31:0] r_pos [3];
    logic [31:0] r_vel [3];
    logic [1:0]  r_ax;
    logic        r_move;
    logic        r_rest;
    logic        r_out_valid;

    logic [65:0] r_acc;
    logic [33:0] r_dist;
    logic [33:0] r_den;
    logic [23:0] r_vm;
    logic [15:0] r_dt;
    logic [31:0] r_out_pos [3];
    logic [31:0] r_out_vel [3];
    logic        r_out_rest;
    logic        r_out_reached;

    logic        w_accept;
    logic        w_slot_free;
    logic [32:0] w_diff;
    logic [32:0] w_neg_diff;
    logic [31:0] w_mag;
    logic [24:0] w_radius;
    logic [23:0] w_sm;
    logic [33:0] w_step;
    logic [33:0] w_sum;
    logic [31:0] w_new_pos;
    logic [31:0] w_new_vel;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    sapstep_pkg::t_iter_req w_iter_req;
    logic        w_iter_done;
    logic [33:0] w_iter_res;

    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;

    // distance along the current axis, target minus position
    assign w_diff     = {r_tgt[r_ax][31], r_tgt[r_ax]} - {r_pos[r_ax][31], r_pos[r_ax]};
    assign w_neg_diff = -w_diff;
    assign w_mag      = w_diff[32] ? w_neg_diff[31:0] : w_diff[31:0];

    assign w_radius = {1'b0, r_ms} + {2'b0, r_ms[23:1]};

    // displacement vm*dt >> 16, signed by direction, then saturating add
    assign w_sm      = w_prod[39:16];
    assign w_step    = w_diff[32] ? -{10'b0, w_sm} : {10'b0, w_sm};
    assign w_sum     = {{2{r_pos[r_ax][31]}}, r_pos[r_ax]} + w_step;
    assign w_new_pos = (w_sum[33:31] == 3'b000 || w_sum[33:31] == 3'b111) ? w_sum[31:0]
                     : (w_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign w_new_vel = w_diff[32] ? -{8'b0, r_vm} : {8'b0, r_vm};

    sapstep_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sapstep_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_iter_req),
        .i_rad   (r_acc),
        .i_num   (w_prod[55:0]),
        .i_den   (r_den),
        .o_done  (w_iter_done),
        .o_res   (w_iter_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sapstep_pkg::ST_IDLE:        if (i_valid) n_state = sapstep_pkg::ST_SQ_MUL;
            sapstep_pkg::ST_SQ_MUL:      n_state = sapstep_pkg::ST_SQ_ACC;
            sapstep_pkg::ST_SQ_ACC:      n_state = (r_ax == 2'd2) ? sapstep_pkg::ST_SQRT_GO
                                                                  : sapstep_pkg::ST_SQ_MUL;
            sapstep_pkg::ST_SQRT_GO:     n_state = sapstep_pkg::ST_SQRT_WAIT;
            sapstep_pkg::ST_SQRT_WAIT:   if (w_iter_done) n_state = sapstep_pkg::ST_DECIDE;
            sapstep_pkg::ST_DECIDE:      n_state = (r_move && r_dist >= sapstep_pkg::REST_LIMIT)
                                                 ? sapstep_pkg::ST_MV_MUL1
                                                 : sapstep_pkg::ST_DONE;
            sapstep_pkg::ST_MV_MUL1:     n_state = sapstep_pkg::ST_MV_DIV_GO;
            sapstep_pkg::ST_MV_DIV_GO:   n_state = sapstep_pkg::ST_MV_DIV_WAIT;
            sapstep_pkg::ST_MV_DIV_WAIT: if (w_iter_done) n_state = sapstep_pkg::ST_MV_MUL2;
            sapstep_pkg::ST_MV_MUL2:     n_state = sapstep_pkg::ST_MV_UPD;
            sapstep_pkg::ST_MV_UPD:      n_state = (r_ax == 2'd2) ? sapstep_pkg::ST_SQ_MUL
                                                                  : sapstep_pkg::ST_MV_MUL1;
            sapstep_pkg::ST_DONE:        if (w_slot_free) n_state = sapstep_pkg::ST_IDLE;
            default:                     n_state = sapstep_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready           = 1'b0;
        w_mul_a           = '0;
        w_mul_b           = '0;
        w_iter_req.start  = 1'b0;
        w_iter_req.is_div = 1'b0;
        unique case (r_state)
            sapstep_pkg::ST_IDLE: o_ready = 1'b1;
            sapstep_pkg::ST_SQ_MUL: begin
                w_mul_a = w_mag;
                w_mul_b = w_mag;
            end
            sapstep_pkg::ST_SQRT_GO: w_iter_req.start = 1'b1;
            sapstep_pkg::ST_MV_MUL1: begin
                w_mul_a = w_mag;
                w_mul_b = {8'b0, r_ms};
            end
            sapstep_pkg::ST_MV_DIV_GO: begin
                w_iter_req.start  = 1'b1;
                w_iter_req.is_div = 1'b1;
            end
            sapstep_pkg::ST_MV_MUL2: begin
                w_mul_a = {8'b0, r_vm};
                w_mul_b = {16'b0, r_dt};
            end
            default: ;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sapstep_pkg::ST_IDLE;
            r_tgt[0]    <= '0;
            r_tgt[1]    <= '0;
            r_tgt[2]    <= '0;
            r_ms        <= sapstep_pkg::MAX_SPEED_RST;
            r_en        <= 1'b1;
            r_tol       <= sapstep_pkg::REACH_TOL_RST;
            r_pos[0]    <= '0;
            r_pos[1]    <= '0;
            r_pos[2]    <= '0;
            r_vel[0]    <= '0;
            r_vel[1]    <= '0;
            r_vel[2]    <= '0;
            r_ax        <= '0;
            r_move      <= 1'b0;
            r_rest      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sapstep_pkg::CFG_TARGET_X:  r_tgt[0] <= i_cfg_data;
                    sapstep_pkg::CFG_TARGET_Y:  r_tgt[1] <= i_cfg_data;
                    sapstep_pkg::CFG_TARGET_Z:  r_tgt[2] <= i_cfg_data;
                    sapstep_pkg::CFG_MAX_SPEED: r_ms     <= i_cfg_data[23:0];
                    sapstep_pkg::CFG_ENABLED:   r_en     <= i_cfg_data[0];
                    sapstep_pkg::CFG_REACH_TOL: r_tol    <= i_cfg_data[23:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                sapstep_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_ax   <= '0;
                        r_rest <= 1'b0;
                        r_move <= (i_func == sapstep_pkg::FUNC_TICK) && r_en;
                        if (i_func == sapstep_pkg::FUNC_PLACE) begin
                            r_pos[0] <= i_place_x;
                            r_pos[1] <= i_place_y;
                            r_pos[2] <= i_place_z;
                        end
                    end
                end
                sapstep_pkg::ST_SQ_ACC: r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                sapstep_pkg::ST_DECIDE: begin
                    if (r_move && r_dist < sapstep_pkg::REST_LIMIT) begin
                        r_vel[0] <= '0;
                        r_vel[1] <= '0;
                        r_vel[2] <= '0;
                        r_rest   <= 1'b1;
                    end
                end
                sapstep_pkg::ST_MV_UPD: begin
                    r_pos[r_ax] <= w_new_pos;
                    r_vel[r_ax] <= w_new_vel;
                    r_ax        <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    // second distance pass measures the new position
                    if (r_ax == 2'd2) r_move <= 1'b0;
                end
                default: ;
            endcase

            if (r_state == sapstep_pkg::ST_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath scratch and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sapstep_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_acc <= '0;
                    r_dt  <= i_dt;
                end
            end
            sapstep_pkg::ST_SQ_ACC:    r_acc <= r_acc + {2'b0, w_prod};
            sapstep_pkg::ST_SQRT_WAIT: if (w_iter_done) r_dist <= w_iter_res;
            sapstep_pkg::ST_DECIDE: begin
                r_den <= (r_dist < {9'b0, w_radius}) ? {9'b0, w_radius} : r_dist;
            end
            sapstep_pkg::ST_MV_DIV_WAIT: if (w_iter_done) r_vm <= w_iter_res[23:0];
            sapstep_pkg::ST_MV_UPD:      if (r_ax == 2'd2) r_acc <= '0;
            sapstep_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    r_out_pos[0]  <= r_pos[0];
                    r_out_pos[1]  <= r_pos[1];
                    r_out_pos[2]  <= r_pos[2];
                    r_out_vel[0]  <= r_vel[0];
                    r_out_vel[1]  <= r_vel[1];
                    r_out_vel[2]  <= r_vel[2];
                    r_out_rest    <= r_rest;
                    r_out_reached <= (r_dist < {10'b0, r_tol});
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_out_pos[0];
    assign o_pos_y     = r_out_pos[1];
    assign o_pos_z     = r_out_pos[2];
    assign o_vel_x     = r_out_vel[0];
    assign o_vel_y     = r_out_vel[1];
    assign o_vel_z     = r_out_vel[2];
    assign o_at_rest   = r_out_rest;
    assign o_reached   = r_out_reached;

    // speed quotient never exceeds max speed
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sapstep_pkg::ST_MV_DIV_WAIT && w_iter_done)
            |-> (w_iter_res <= {10'b0, r_ms}))
        else $error("divide quotient above max speed");

    a_rest_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_rest) |-> (o_vel_x == 32'd0 && o_vel_y == 32'd0 && o_vel_z == 32'd0))
        else $error("resting result with nonzero velocity");

    // axis counter must wrap before each root pass
    a_axis_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sapstep_pkg::ST_SQRT_GO) |-> (r_ax == 2'd0 && r_state != $past(r_state)))
        else $error("axis counter not wrapped at root start");

endmodule

>>> test/tb_seek_arrive_position_step_core.sv
// ----------------------------------------------------------------------------
// tb_seek_arrive_position_step_core: self-checking bench for the seek/arrive step
// Sends tick and place requests in random bursts against a result side that
// stalls on its own pattern. A bench-side model of the agent predicts every
// result, and each result is checked field by field in order. The directed
// tests cover register extremes, the rest and reach boundaries, a frozen
// agent, zero speed, ignored register writes and a long output stall.
// ----------------------------------------------------------------------------
module tb_seek_arrive_position_step_core;

    typedef logic [2:0][31:0] t_vec3;   // [0] = x, [1] = y, [2] = z

    typedef struct packed {
        t_vec3 pos;
        t_vec3 vel;
        logic  at_rest;
        logic  reached;
    } t_step_result;

    // indexes past the last register; writes to them must be dropped
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [15:0] i_dt;
    logic [31:0] i_place_x;
    logic [31:0] i_place_y;
    logic [31:0] i_place_z;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic [31:0] o_pos_z;
    logic [31:0] o_vel_x;
    logic [31:0] o_vel_y;
    logic [31:0] o_vel_z;
    logic        o_at_rest;
    logic        o_reached;

    // agent model state and its copy of the registers
    t_vec3       goal;
    t_vec3       agent_pos;
    t_vec3       agent_vel;
    logic [23:0] speed_cap;
    logic [23:0] reach_tol;
    logic        moving_enabled;

    t_step_result predicted_steps[$];
    int           error_count = 0;
    int           rx_hold_req = 0;
    int           burst_left  = 0;

    seek_arrive_position_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_dt        (i_dt),
        .i_place_x   (i_place_x),
        .i_place_y   (i_place_y),
        .i_place_z   (i_place_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_vel_z     (o_vel_z),
        .o_at_rest   (o_at_rest),
        .o_reached   (o_reached)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // agent model
    // ------------------------------------------------------------------

    // floor of the euclidean distance from p to the goal, Q.16 units
    function automatic logic [33:0] dist_to_goal(input t_vec3 p);
        logic [69:0]        acc;
        logic [69:0]        aw;
        logic [69:0]        cw;
        logic signed [33:0] diff;
        logic [33:0]        root;
        logic [33:0]        trial;
        int                 i;
        int                 b;
        acc = '0;
        for (i = 0; i < 3; i++) begin
            diff = $signed({{2{goal[i][31]}}, goal[i]}) - $signed({{2{p[i][31]}}, p[i]});
            aw = diff[33] ? -diff : diff;
            acc = acc + aw * aw;
        end
        root = '0;
        for (b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            cw = trial;
            if (cw * cw <= acc) root = trial;
        end
        return root;
    endfunction

    function automatic t_step_result step_agent(input logic func, input logic [15:0] dt,
                                                input t_vec3 place);
        t_step_result       res;
        logic [33:0]        span;
        logic [33:0]        radius;
        logic [33:0]        den;
        logic signed [33:0] diff;
        logic [63:0]        mag;
        logic [63:0]        vm;
        logic [63:0]        sm;
        logic [63:0]        vneg;
        logic signed [63:0] moved;
        int                 i;
        res.at_rest = 1'b0;
        if (func == sapstep_pkg::FUNC_PLACE) begin
            agent_pos = place;
        end else if (moving_enabled) begin
            span = dist_to_goal(agent_pos);
            if (span < sapstep_pkg::REST_LIMIT) begin
                agent_vel = '0;
                res.at_rest = 1'b1;
            end else begin
                // arrival radius is 1.5x max speed; slow down linearly inside it
                radius = {10'd0, speed_cap} + {11'd0, speed_cap[23:1]};
                den = (span < radius) ? radius : span;
                for (i = 0; i < 3; i++) begin
                    diff = $signed({{2{goal[i][31]}}, goal[i]})
                         - $signed({{2{agent_pos[i][31]}}, agent_pos[i]});
                    mag = diff[33] ? -diff : diff;
                    vm = (mag * {40'd0, speed_cap}) / {30'd0, den};
                    sm = (vm * {48'd0, dt}) >> 16;
                    vneg = 64'd0 - vm;
                    agent_vel[i] = diff[33] ? vneg[31:0] : vm[31:0];
                    moved = $signed({{32{agent_pos[i][31]}}, agent_pos[i]})
                          + (diff[33] ? -$signed(sm) : $signed(sm));
                    if (moved > 64'sd2147483647)
                        agent_pos[i] = 32'h7FFF_FFFF;
                    else if (moved < -64'sd2147483648)
                        agent_pos[i] = 32'h8000_0000;
                    else
                        agent_pos[i] = moved[31:0];
                end
            end
        end
        res.pos = agent_pos;
        res.vel = agent_vel;
        res.reached = (dist_to_goal(agent_pos) < {10'd0, reach_tol});
        return res;
    endfunction

    function automatic void apply_reg(input logic [2:0] index, input logic [31:0] data);
        case (index)
            sapstep_pkg::CFG_TARGET_X:  goal[0] = data;
            sapstep_pkg::CFG_TARGET_Y:  goal[1] = data;
            sapstep_pkg::CFG_TARGET_Z:  goal[2] = data;
            sapstep_pkg::CFG_MAX_SPEED: speed_cap = data[23:0];
            sapstep_pkg::CFG_ENABLED:   moving_enabled = data[0];
            sapstep_pkg::CFG_REACH_TOL: reach_tol = data[23:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: stall pattern and checking
    // ------------------------------------------------------------------

    initial begin : result_stall
        int   hold_left;
        int   stretch_left;
        int   mode;
        logic rdy;
        hold_left = 0;
        stretch_left = 0;
        mode = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(20, 200);
                end
                stretch_left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ((stretch_left % 7) < 3);
                endcase
            end
            i_ready <= rdy;
        end
    end

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_result();
        t_step_result want;
        t_step_result got;
        int           i;
        got.pos = {o_pos_z, o_pos_y, o_pos_x};
        got.vel = {o_vel_z, o_vel_y, o_vel_x};
        got.at_rest = o_at_rest;
        got.reached = o_reached;
        if (predicted_steps.size() == 0) begin
            note_failure($sformatf("result with no request pending, pos %h vel %h",
                                   got.pos, got.vel));
        end else begin
            want = predicted_steps.pop_front();
            for (i = 0; i < 3; i++) begin
                if (got.pos[i] !== want.pos[i])
                    note_failure($sformatf("pos axis %0d expected %h got %h",
                                           i, want.pos[i], got.pos[i]));
                if (got.vel[i] !== want.vel[i])
                    note_failure($sformatf("vel axis %0d expected %h got %h",
                                           i, want.vel[i], got.vel[i]));
            end
            if (got.at_rest !== want.at_rest)
                note_failure($sformatf("at_rest expected %b got %b", want.at_rest, got.at_rest));
            if (got.reached !== want.reached)
                note_failure($sformatf("reached expected %b got %b", want.reached, got.reached));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_result();
    end

    // ------------------------------------------------------------------
    // request side; every task starts and ends on a falling edge
    // ------------------------------------------------------------------

    task automatic send_item(input logic func, input logic [15:0] dt, input t_vec3 place);
        int gap;
        i_valid   <= 1'b1;
        i_func    <= func;
        i_dt      <= dt;
        i_place_x <= place[0];
        i_place_y <= place[1];
        i_place_z <= place[2];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted_steps.push_back(step_agent(func, dt, place));
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 220);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // unused place fields carry noise on a tick
    task automatic tick_at(input logic [15:0] dt);
        send_item(sapstep_pkg::FUNC_TICK, dt, {$urandom, $urandom, $urandom});
    endtask

    task automatic place_at(input t_vec3 spot);
        send_item(sapstep_pkg::FUNC_PLACE, 16'($urandom_range(0, 65535)), spot);
    endtask

    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        while (predicted_steps.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly ticks so the agent converges; places jump it near the goal or anywhere
    task automatic random_request();
        int    pick;
        int    i;
        t_vec3 spot;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            place_at({$urandom, $urandom, $urandom});
        end else if (pick < 22) begin
            for (i = 0; i < 3; i++)
                spot[i] = goal[i] + ($signed($urandom) >>> $urandom_range(0, 31));
            place_at(spot);
        end else if (pick < 27) begin
            tick_at(16'hFFFF);
        end else if (pick < 30) begin
            tick_at(16'h0000);
        end else begin
            tick_at(16'($urandom_range(0, 65535)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_reset_state();
        tick_at(16'hFFFF);  // agent sits on the goal after reset
        place_at({32'd0, 32'h8000_0000, 32'h7FFF_FFFF});
        tick_at(16'hFFFF);
    endtask

    task automatic test_rest_boundary();
        place_at({32'd0, 32'd0, 32'd654});
        tick_at(16'hFFFF);
        place_at({32'd0, 32'd0, 32'd655});
        tick_at(16'hFFFF);
        // diagonal distance just under the rest limit
        place_at({32'd0, -32'sd463, 32'd463});
        tick_at(16'hFFFF);
    endtask

    task automatic test_field_extremes();
        write_reg(sapstep_pkg::CFG_TARGET_X, 32'h7FFF_FFFF);
        write_reg(sapstep_pkg::CFG_TARGET_Y, 32'h8000_0000);
        write_reg(sapstep_pkg::CFG_TARGET_Z, 32'h7FFF_FFFF);
        write_reg(sapstep_pkg::CFG_MAX_SPEED, 32'hFFFF_FFFF);
        place_at({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        tick_at(16'hFFFF);
        tick_at(16'h0000);
        // inside the arrival radius, right at the corner of the range
        place_at({32'h7FFE_FFFF, 32'h8001_0000, 32'h7FFE_FFFF});
        tick_at(16'hFFFF);
    endtask

    task automatic test_zero_speed();
        write_reg(sapstep_pkg::CFG_MAX_SPEED, 32'h0000_0000);
        place_at({32'h0064_0000, 32'hFF9C_0000, 32'd0});
        tick_at(16'hFFFF);
    endtask

    task automatic test_frozen_agent();
        write_reg(sapstep_pkg::CFG_MAX_SPEED, {8'd0, sapstep_pkg::MAX_SPEED_RST});
        write_reg(sapstep_pkg::CFG_ENABLED, 32'hFFFF_FFFE);
        tick_at(16'hFFFF);
        place_at({$urandom, $urandom, $urandom});
        tick_at(16'hFFFF);
        write_reg(sapstep_pkg::CFG_ENABLED, 32'd1);
    endtask

    task automatic test_reach_tolerance();
        write_reg(sapstep_pkg::CFG_TARGET_X, 32'd0);
        write_reg(sapstep_pkg::CFG_TARGET_Y, 32'd0);
        write_reg(sapstep_pkg::CFG_TARGET_Z, 32'd0);
        write_reg(sapstep_pkg::CFG_REACH_TOL, 32'd0);
        place_at('0);
        tick_at(16'hFFFF);
        write_reg(sapstep_pkg::CFG_REACH_TOL, 32'hFFFF_FFFF);
        place_at({32'h00FF_FFFE, 32'd0, 32'd0});
        tick_at(16'h0000);
        place_at({32'h0100_0000, 32'd0, 32'd0});
    endtask

    task automatic test_ignored_index();
        write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_7, 32'hFFFF_FFFF);
        tick_at(16'hFFFF);
        write_reg(sapstep_pkg::CFG_REACH_TOL, {8'd0, sapstep_pkg::REACH_TOL_RST});
    endtask

    // result side holds off while requests keep coming, so the input backs up
    task automatic test_output_backpressure();
        rx_hold_req = HOLD_CYCLES;
        repeat (6) random_request();
        drain();
    endtask

    task automatic program_phase(input int phase);
        logic [23:0] speed;
        logic [23:0] tol;
        logic [31:0] junk;
        t_vec3       spot;
        int          i;
        junk = $urandom;
        case (phase)
            0: begin
                speed = 24'hFF_FFFF;
                tol   = 24'hFF_FFFF;
            end
            1: begin
                speed = 24'd0;
                tol   = 24'd0;
            end
            2: begin
                speed = sapstep_pkg::MAX_SPEED_RST;
                tol   = sapstep_pkg::REACH_TOL_RST;
            end
            default: begin
                speed = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 23));
                tol   = 24'($urandom_range(0, 24'hFF_FFFF) >> $urandom_range(4, 23));
            end
        endcase
        if (phase == 2)
            spot = '0;
        else if (phase == 3)
            spot = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        else
            for (i = 0; i < 3; i++) spot[i] = $signed($urandom) >>> $urandom_range(0, 16);
        write_reg(sapstep_pkg::CFG_TARGET_X, spot[0]);
        write_reg(sapstep_pkg::CFG_TARGET_Y, spot[1]);
        write_reg(sapstep_pkg::CFG_TARGET_Z, spot[2]);
        write_reg(sapstep_pkg::CFG_MAX_SPEED, {junk[31:24], speed});
        write_reg(sapstep_pkg::CFG_ENABLED, {junk[31:1], (phase != 5)});
        write_reg(sapstep_pkg::CFG_REACH_TOL, {junk[23:16], tol});
    endtask

    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < PHASES; phase++) begin
            program_phase(phase);
            repeat (PHASE_ITEMS) random_request();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_func      = sapstep_pkg::FUNC_TICK;
        i_dt        = '0;
        i_place_x   = '0;
        i_place_y   = '0;
        i_place_z   = '0;
        goal           = '0;
        agent_pos      = '0;
        agent_vel      = '0;
        speed_cap      = sapstep_pkg::MAX_SPEED_RST;
        reach_tol      = sapstep_pkg::REACH_TOL_RST;
        moving_enabled = 1'b1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_rest_boundary();
        test_field_extremes();
        test_zero_speed();
        test_frozen_agent();
        test_reach_tolerance();
        test_ignored_index();
        test_output_backpressure();
        test_random_phases();

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0 && predicted_steps.size() == 0)
            $display("tb_seek_arrive_position_step_core: PASS");
        else
            $display("tb_seek_arrive_position_step_core: FAIL");
        $finish;
    end

    initial begin
        #(64'd100_000_000);
        $display("tb_seek_arrive_position_step_core: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sapstep_pkg.sv
hw/rtl/sapstep_mul.sv
hw/rtl/sapstep_iter.sv
hw/rtl/seek_arrive_position_step_core.sv
test/tb_seek_arrive_position_step_core.sv
